// ----- hdl/dtg711_pkg.sv -----
// Shared constants, codes and types of the dual-tone G.711 generator.
package dtg711_pkg;

    // Fixed-point format of phasors and coefficients.
    localparam int FRAC_BITS = 30;
    localparam int PH_W      = 32;
    localparam int PROD_W    = 2 * PH_W;
    localparam int RND_W     = PROD_W - FRAC_BITS;

    // Sample and code widths, and the shift from phasor scale to sample scale.
    localparam int SAMPLE_W  = 16;
    localparam int CODE_W    = 8;
    localparam int SAMPLE_SHIFT = FRAC_BITS - 13;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = CODE_W + SAMPLE_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Multiply schedule: eight operations per tone, the two tones interleaved.
    localparam int NUM_TONES = 2;
    localparam int NUM_OPS   = 8;
    localparam int ISSUE_N   = NUM_TONES * NUM_OPS;
    localparam int CNT_W     = $clog2(ISSUE_N);

    // Fixed-point one.
    localparam logic signed [PH_W-1:0] ONE_FX = PH_W'(64'sd1 <<< FRAC_BITS);

    // Companding law codes.
    localparam logic LAW_MU = 1'b0;
    localparam logic LAW_A  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_COS  = 3'd0,
        REG_FIRST_SIN  = 3'd1,
        REG_SECOND_COS = 3'd2,
        REG_SECOND_SIN = 3'd3,
        REG_LAW_SELECT = 3'd4
    } dtg711_reg_t;

    // Multiply operations of one tone update, in issue order.
    typedef enum logic [CNT_W-2:0] {
        OP_RE_C  = 3'd0,   // re * cos
        OP_RE_S  = 3'd1,   // re * sin
        OP_IM_S  = 3'd2,   // im * sin, closes the new real part
        OP_IM_C  = 3'd3,   // im * cos, closes the new imaginary part
        OP_RE_SQ = 3'd4,   // re * re
        OP_IM_SQ = 3'd5,   // im * im, closes the correction factor
        OP_RE_T  = 3'd6,   // re * factor
        OP_IM_T  = 3'd7    // im * factor
    } dtg711_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SUM,
        ST_ENC
    } dtg711_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       restart;
        logic       issue;
        logic       tone;
        dtg711_op_t op;
        logic       sum;
        logic       load_out;
    } dtg711_cmd_t;

endpackage

// ----- hdl/dtg711_g711.sv -----
// G.711 compressor: mu-law or A-law byte from a 16-bit linear sample.
module dtg711_g711 (
    input  logic signed [dtg711_pkg::SAMPLE_W-1:0] sample,
    input  logic                                   law,
    output logic [dtg711_pkg::CODE_W-1:0]          code
);
    import dtg711_pkg::*;

    localparam logic [13:0] U_CLIP = 14'd8159;
    localparam logic [13:0] U_BIAS = 14'd33;

    logic [11:0] a_mag;
    logic [2:0]  a_seg;
    logic [3:0]  a_man;
    logic [7:0]  a_code;
    logic [13:0] u_base;
    logic [13:0] u_mag;
    logic [2:0]  u_seg;
    logic [3:0]  u_man;
    logic [7:0]  u_mask;
    logic [7:0]  u_code;

    // A-law: magnitude on the top 13 bits, segment from the leading one.
    always_comb
    begin
        a_mag = sample[SAMPLE_W-1] ? ~sample[14:3] : sample[14:3];
        a_seg = 3'd0;
        for (int i = 5; i < 12; i++)
        begin
            if (a_mag[i])
            begin
                a_seg = 3'(i - 4);
            end
        end
        a_man  = (a_seg == 3'd0) ? a_mag[4:1] : 4'(a_mag >> a_seg);
        a_code = {1'b0, a_seg, a_man} ^ (sample[SAMPLE_W-1] ? 8'h55 : 8'hD5);
    end

    // Mu-law: biased magnitude on the top 14 bits, clipped at full scale.
    always_comb
    begin
        if (sample[SAMPLE_W-1])
        begin
            u_base = {1'b0, ~sample[14:2]} + 14'd1;
            u_mask = 8'h7F;
        end
        else
        begin
            u_base = {1'b0, sample[14:2]};
            u_mask = 8'hFF;
        end
        u_mag = ((u_base > U_CLIP) ? U_CLIP : u_base) + U_BIAS;
        u_seg = 3'd0;
        for (int i = 6; i < 13; i++)
        begin
            if (u_mag[i])
            begin
                u_seg = 3'(i - 5);
            end
        end
        u_man = 4'(u_mag >> ({1'b0, u_seg} + 4'd1));
        if (u_mag[13])
        begin
            u_code = 8'h7F ^ u_mask;
        end
        else
        begin
            u_code = {1'b0, u_seg, u_man} ^ u_mask;
        end
    end

    assign code = (law == LAW_A) ? a_code : u_code;

endmodule

// ----- hdl/dtg711_dpath.sv -----
// Datapath: coefficient registers, phasors, shared multiplier, rounding and output register.
module dtg711_dpath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dtg711_pkg::dtg711_cmd_t                 cmd,
    input  logic                                    cfg_wr_en,
    input  logic [dtg711_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dtg711_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [dtg711_pkg::CODE_W-1:0]           code_byte,
    output logic signed [dtg711_pkg::SAMPLE_W-1:0]  linear_sample
);
    import dtg711_pkg::*;

    localparam int WIDE_W = RND_W + 2;
    localparam int QW     = PH_W + 1 - SAMPLE_SHIFT;
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [WIDE_W-1:0] TWO_FX = WIDE_W'(64'sd2 <<< FRAC_BITS);

    // Configuration.
    logic signed [PH_W-1:0]   cos_reg [NUM_TONES];
    logic signed [PH_W-1:0]   sin_reg [NUM_TONES];
    logic                     law_reg;

    // Phasors and per-tone scratch.
    logic signed [PH_W-1:0]   re_reg   [NUM_TONES];
    logic signed [PH_W-1:0]   im_reg   [NUM_TONES];
    logic signed [PH_W-1:0]   t_reg    [NUM_TONES];
    logic signed [RND_W-1:0]  accr_reg [NUM_TONES];
    logic signed [RND_W-1:0]  acci_reg [NUM_TONES];

    // Multiplier stage.
    logic signed [PH_W-1:0]   op_a;
    logic signed [PH_W-1:0]   op_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     wb_valid_reg;
    logic                     wb_tone_reg;
    dtg711_op_t               wb_op_reg;

    // Writeback stage.
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [RND_W-1:0]  rnd_val;
    logic signed [WIDE_W-1:0] r_wide;
    logic signed [WIDE_W-1:0] accr_w;
    logic signed [WIDE_W-1:0] acci_w;

    // Sample rounding and output.
    logic signed [PH_W:0]     tone_sum;
    logic [QW-1:0]            q_val;
    logic [SAMPLE_SHIFT-1:0]  rem_val;
    logic                     q_inc;
    logic [QW:0]              q_rnd;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CODE_W-1:0]        enc_code;
    logic [CODE_W-1:0]        out_code_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;

    function automatic logic signed [PH_W-1:0] sat_ph(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-PH_W:0] top;
        top = v[WIDE_W-1:PH_W-1];
        if ((&top) || !(|top))
        begin
            sat_ph = v[PH_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            sat_ph = {1'b1, {(PH_W-1){1'b0}}};
        end
        else
        begin
            sat_ph = {1'b0, {(PH_W-1){1'b1}}};
        end
    endfunction

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg[0] <= ONE_FX;
            cos_reg[1] <= ONE_FX;
            sin_reg[0] <= '0;
            sin_reg[1] <= '0;
            law_reg    <= LAW_MU;
        end
        else if (cfg_wr_en)
        begin
            case (dtg711_reg_t'(cfg_index))
                REG_FIRST_COS:  cos_reg[0] <= cfg_data[PH_W-1:0];
                REG_FIRST_SIN:  sin_reg[0] <= cfg_data[PH_W-1:0];
                REG_SECOND_COS: cos_reg[1] <= cfg_data[PH_W-1:0];
                REG_SECOND_SIN: sin_reg[1] <= cfg_data[PH_W-1:0];
                REG_LAW_SELECT: law_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.op)
            OP_RE_C:  begin op_a = re_reg[cmd.tone]; op_b = cos_reg[cmd.tone]; end
            OP_RE_S:  begin op_a = re_reg[cmd.tone]; op_b = sin_reg[cmd.tone]; end
            OP_IM_S:  begin op_a = im_reg[cmd.tone]; op_b = sin_reg[cmd.tone]; end
            OP_IM_C:  begin op_a = im_reg[cmd.tone]; op_b = cos_reg[cmd.tone]; end
            OP_RE_SQ: begin op_a = re_reg[cmd.tone]; op_b = re_reg[cmd.tone];  end
            OP_IM_SQ: begin op_a = im_reg[cmd.tone]; op_b = im_reg[cmd.tone];  end
            OP_RE_T:  begin op_a = re_reg[cmd.tone]; op_b = t_reg[cmd.tone];   end
            default:  begin op_a = im_reg[cmd.tone]; op_b = t_reg[cmd.tone];   end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Product register and the tag that follows it to writeback.
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        wb_tone_reg <= cmd.tone;
        wb_op_reg   <= cmd.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= cmd.issue;
        end
    end

    // Round half up to the fixed-point grid.
    assign prod_rnd = prod_reg + HALF_P;
    assign rnd_val  = prod_rnd[PROD_W-1:FRAC_BITS];
    assign r_wide   = WIDE_W'(rnd_val);
    assign accr_w   = WIDE_W'(accr_reg[wb_tone_reg]);
    assign acci_w   = WIDE_W'(acci_reg[wb_tone_reg]);

    // Partial sums and the magnitude correction factor.
    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            unique case (wb_op_reg)
                OP_RE_C, OP_RE_SQ: accr_reg[wb_tone_reg] <= rnd_val;
                OP_RE_S:           acci_reg[wb_tone_reg] <= rnd_val;
                OP_IM_SQ:          t_reg[wb_tone_reg]    <= sat_ph(TWO_FX - (accr_w + r_wide));
                default:           ;
            endcase
        end
    end

    // Phasor state: restart to 1+0j, otherwise updated by writeback.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_reg[0] <= ONE_FX;
            re_reg[1] <= ONE_FX;
            im_reg[0] <= '0;
            im_reg[1] <= '0;
        end
        else if (cmd.restart)
        begin
            re_reg[0] <= ONE_FX;
            re_reg[1] <= ONE_FX;
            im_reg[0] <= '0;
            im_reg[1] <= '0;
        end
        else if (wb_valid_reg)
        begin
            unique case (wb_op_reg)
                OP_IM_S: re_reg[wb_tone_reg] <= sat_ph(accr_w - r_wide);
                OP_IM_C: im_reg[wb_tone_reg] <= sat_ph(acci_w + r_wide);
                OP_RE_T: re_reg[wb_tone_reg] <= sat_ph(r_wide);
                OP_IM_T: im_reg[wb_tone_reg] <= sat_ph(r_wide);
                default: ;
            endcase
        end
    end

    // Sum of real parts, round half to even, saturate to the sample range.
    always_comb
    begin
        tone_sum = {re_reg[0][PH_W-1], re_reg[0]} + {re_reg[1][PH_W-1], re_reg[1]};
        q_val    = tone_sum[PH_W:SAMPLE_SHIFT];
        rem_val  = tone_sum[SAMPLE_SHIFT-1:0];
        q_inc    = rem_val[SAMPLE_SHIFT-1] & ((|rem_val[SAMPLE_SHIFT-2:0]) | q_val[0]);
        q_rnd    = {q_val[QW-1], q_val} + (QW+1)'(q_inc);
        if ((&q_rnd[QW:SAMPLE_W-1]) || !(|q_rnd[QW:SAMPLE_W-1]))
        begin
            sample_next = q_rnd[SAMPLE_W-1:0];
        end
        else if (q_rnd[QW])
        begin
            sample_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sample_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    dtg711_g711 u_enc (
        .sample (sample_reg),
        .law    (law_reg),
        .code   (enc_code)
    );

    // Sample register and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sample_reg <= sample_next;
        end
        if (cmd.load_out)
        begin
            out_code_reg   <= enc_code;
            out_sample_reg <= sample_reg;
        end
    end

    assign code_byte     = out_code_reg;
    assign linear_sample = out_sample_reg;

    // Writeback only follows an issued multiply.
    a_wb_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> $past(cmd.issue))
        else $error("writeback without an issued multiply");

    // A restart never coincides with a phasor writeback.
    a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |-> !wb_valid_reg)
        else $error("restart during phasor update");

    // The sample is rounded only after the last multiply has been written back.
    a_sum_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |-> ($past(wb_valid_reg) && !wb_valid_reg))
        else $error("sample formed before phasor update finished");

endmodule

// ----- hdl/dtg711_ctrl.sv -----
// Controller: stream handshakes and the sequence of multiply, round and encode steps.
module dtg711_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_restart,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output dtg711_pkg::dtg711_cmd_t cmd
);
    import dtg711_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ISSUE_N - 1);

    dtg711_state_t     state_reg;
    dtg711_state_t     state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state, issue counter and output occupancy.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath and handshake outputs.
    always_comb
    begin
        cmd          = '0;
        cmd.tone     = cnt_reg[0];
        cmd.op       = dtg711_op_t'(cnt_reg[CNT_W-1:1]);
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.restart = s_tvalid && s_restart;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
            end
            ST_ENC:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = cmd;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The output register is loaded only when empty or being emptied.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while still waiting");

    // An accepted item starts the multiply sequence from its first operation.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("multiply sequence did not start");

    // The drain step follows the full set of issued multiplies.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> ($past(state_reg) == ST_RUN && $past(cnt_reg) == CNT_LAST))
        else $error("multiply sequence cut short");

    // A result appears only through a load of the output register.
    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid without load");

endmodule

// ----- hdl/dual_tone_generator_g711_core.sv -----
// Top level of the dual-tone generator with G.711 output.
//
// Each input item on the s_ stream asks for one 8 kHz sample; its only field,
// restart, sets both tone phasors to 1+0j before the sample is made. Each item
// gives exactly one result item on the m_ stream: the G.711 byte and the
// rounded linear sample. Rotation coefficients and the companding law are
// written through cfg_wr_en / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Sixteen multiplies (eight per tone, the two tones interleaved) run through
// one shared 32x32 multiplier, one per cycle, followed by writeback, sample
// rounding and coding; a new item is taken only after the result of the last
// one has been loaded into the output register. If the receiver stalls, the
// result stays in the output register; the next item is still accepted and
// computed, and waits in its coding step until the output register frees.
// Reset puts the coefficients to 1+0j steps, selects mu-law and sets both
// phasors to 1+0j; no result is pending afterwards.
module dual_tone_generator_g711_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [dtg711_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtg711_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [dtg711_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] restart, rest zero
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [dtg711_pkg::OUT_TDATA_W-1:0]     m_tdata    // [7:0] code_byte, [23:8] linear_sample
);
    import dtg711_pkg::*;

    dtg711_cmd_t                cmd;
    logic [CODE_W-1:0]          code_byte;
    logic signed [SAMPLE_W-1:0] linear_sample;

    dtg711_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_restart (s_tdata[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    dtg711_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .code_byte     (code_byte),
        .linear_sample (linear_sample)
    );

    // Result packing, first field in the lowest bits.
    assign m_tdata = {linear_sample, code_byte};

endmodule

// ----- test/dual_tone_generator_g711_core_tb.sv -----
// Self-checking testbench for the dual-tone G.711 generator core.
import dtg711_pkg::*;

// One predicted result item: G.711 byte and rounded linear sample.
typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [SAMPLE_W-1:0] sample;
} g711_sample_t;

// Bit-true tone predictor and queue of the samples still owed by the block.
class tone_scoreboard;
    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

    longint coef_cos[2];
    longint coef_sin[2];
    logic   law_sel;
    longint ph_re[2];
    longint ph_im[2];

    g711_sample_t owed_q[$];
    int errors;
    int checked;
    int restarts;
    int mu_count;
    int a_count;
    int clipped;

    function new();
        coef_cos[0] = longint'(1) <<< FRAC_BITS;
        coef_cos[1] = longint'(1) <<< FRAC_BITS;
        coef_sin[0] = 0;
        coef_sin[1] = 0;
        law_sel     = LAW_MU;
        restart_phasors();
    endfunction

    function void restart_phasors();
        ph_re[0] = longint'(1) <<< FRAC_BITS;
        ph_re[1] = longint'(1) <<< FRAC_BITS;
        ph_im[0] = 0;
        ph_im[1] = 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Register writes as the block applies them; spare indexes change nothing.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FIRST_COS:  coef_cos[0] = longint'($signed(data));
            REG_FIRST_SIN:  coef_sin[0] = longint'($signed(data));
            REG_SECOND_COS: coef_cos[1] = longint'($signed(data));
            REG_SECOND_SIN: coef_sin[1] = longint'($signed(data));
            REG_LAW_SELECT: law_sel = data[0];
            default: ;
        endcase
    endfunction

    // Fixed-point product, rounded half up to FRAC_BITS fraction bits.
    function longint fx_mul(longint a, longint b);
        return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function longint sat32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // One rotation of tone k followed by the first-order magnitude correction.
    function void rotate(int k);
        longint nr;
        longint ni;
        longint mag;
        longint t;
        nr = sat32(fx_mul(ph_re[k], coef_cos[k]) - fx_mul(ph_im[k], coef_sin[k]));
        ni = sat32(fx_mul(ph_re[k], coef_sin[k]) + fx_mul(ph_im[k], coef_cos[k]));
        mag = fx_mul(nr, nr) + fx_mul(ni, ni);
        t = sat32((longint'(2) <<< FRAC_BITS) - mag);
        ph_re[k] = sat32(fx_mul(nr, t));
        ph_im[k] = sat32(fx_mul(ni, t));
    endfunction

    // A-law coder working on the top 13 bits of the linear sample.
    function logic [7:0] alaw_code(int x);
        logic [7:0] mask;
        logic [7:0] code;
        int mag;
        int seg;
        if (x >= 0)
        begin
            mask = 8'hD5;
            mag  = x >>> 3;
        end
        else
        begin
            mask = 8'h55;
            mag  = (-1 - x) >>> 3;
        end
        seg = 0;
        while (seg < 8 && mag > ((32 << seg) - 1))
            seg++;
        if (seg == 8)
            return 8'h7F ^ mask;
        if (seg < 2)
            code = 8'((seg << 4) | ((mag >>> 1) & 15));
        else
            code = 8'((seg << 4) | ((mag >>> seg) & 15));
        return code ^ mask;
    endfunction

    // Mu-law coder working on the top 14 bits, biased by 33 before segmenting.
    function logic [7:0] mulaw_code(int x);
        logic [7:0] mask;
        logic [7:0] code;
        int mag;
        int seg;
        if (x >= 0)
        begin
            mask = 8'hFF;
            mag  = x >>> 2;
        end
        else
        begin
            mask = 8'h7F;
            mag  = 1 + ((-1 - x) >>> 2);
        end
        if (mag > 8159)
            mag = 8159;
        mag += 33;
        seg = 0;
        while (seg < 8 && mag > ((64 << seg) - 1))
            seg++;
        if (seg == 8)
            return 8'h7F ^ mask;
        code = 8'((seg << 4) | ((mag >>> (seg + 1)) & 15));
        return code ^ mask;
    endfunction

    // Advance both tones for an accepted item and queue the sample it owes.
    function void note_input(logic restart);
        longint sum;
        longint q;
        longint rem;
        longint half;
        g711_sample_t r;
        if (restart)
        begin
            restarts++;
            restart_phasors();
        end
        rotate(0);
        rotate(1);
        // Scale to sample units with round half to even.
        sum  = ph_re[0] + ph_re[1];
        q    = sum >>> SAMPLE_SHIFT;
        rem  = sum - (q <<< SAMPLE_SHIFT);
        half = longint'(1) <<< (SAMPLE_SHIFT - 1);
        if (rem > half || (rem == half && (q & 1) != 0))
            q++;
        if (q > 32767)
        begin
            q = 32767;
            clipped++;
        end
        else if (q < -32768)
        begin
            q = -32768;
            clipped++;
        end
        r.sample = q[SAMPLE_W-1:0];
        if (law_sel == LAW_A)
        begin
            r.code = alaw_code(int'(q));
            a_count++;
        end
        else
        begin
            r.code = mulaw_code(int'(q));
            mu_count++;
        end
        owed_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
        if (errors < 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Compare a result item with the oldest owed sample, field by field.
    task check_result(logic [OUT_TDATA_W-1:0] data);
        g711_sample_t want;
        if (owed_q.size() == 0)
        begin
            report_mismatch($sformatf("result %h arrived with nothing owed", data));
            return;
        end
        want = owed_q.pop_front();
        checked++;
        if (data[7:0] !== want.code)
            report_mismatch($sformatf("sample %0d code_byte %h, predicted %h",
                                      checked, data[7:0], want.code));
        if (data[23:8] !== want.sample)
            report_mismatch($sformatf("sample %0d linear_sample %0d, predicted %0d",
                                      checked, $signed(data[23:8]), $signed(want.sample)));
    endtask
endclass

module dual_tone_generator_g711_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STALL_LIMIT = 2000;
    localparam int  END_WAIT    = 40;
    localparam real TWO_PI      = 6.283185307179586;
    localparam real SAMPLE_HZ   = 8000.0;
    localparam real Q30_ONE     = 1073741824.0;

    // Register indexes the block does not implement.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Full-scale step coefficients.
    localparam logic [CFG_DATA_W-1:0] COEF_POS_ONE = 32'h4000_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_NEG_ONE = 32'hC000_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_MAX     = 32'h7FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] COEF_MIN     = 32'h8000_0000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    tone_scoreboard sb = new();
    int sender_idle = 0;
    int recv_stall = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    dual_tone_generator_g711_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 125 MHz clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random back-pressure at the current stall rate.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // Monitor both streams at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata[0]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: too long without any item moving on either stream.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function logic [CFG_DATA_W-1:0] to_q30(real v);
        return CFG_DATA_W'(longint'(v * Q30_ONE));
    endfunction

    // One register write; the enable stays high until cfg_end.
    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task cfg_end();
        cfg_wr_en <= 1'b0;
    endtask

    task set_tones(logic [CFG_DATA_W-1:0] c0, logic [CFG_DATA_W-1:0] s0,
                   logic [CFG_DATA_W-1:0] c1, logic [CFG_DATA_W-1:0] s1, logic law);
        cfg_write(REG_FIRST_COS, c0);
        cfg_write(REG_FIRST_SIN, s0);
        cfg_write(REG_SECOND_COS, c1);
        cfg_write(REG_SECOND_SIN, s1);
        cfg_write(REG_LAW_SELECT, CFG_DATA_W'(law));
        cfg_end();
        settings_used++;
    endtask

    // Coefficients of one tone: mostly a real frequency, sometimes raw values.
    task pick_tone(output logic [CFG_DATA_W-1:0] c, output logic [CFG_DATA_W-1:0] s);
        int  mode;
        real w;
        mode = $urandom_range(9);
        if (mode < 7)
        begin
            w = TWO_PI * (real'($urandom_range(3999)) + real'($urandom_range(999)) / 1000.0)
                / SAMPLE_HZ;
            c = to_q30($cos(w));
            s = to_q30($sin(w));
        end
        else if (mode < 9)
        begin
            c = CFG_DATA_W'(longint'($urandom_range(32'h8000_0000)) - (longint'(1) <<< 30));
            s = CFG_DATA_W'(longint'($urandom_range(32'h8000_0000)) - (longint'(1) <<< 30));
        end
        else
        begin
            c = $urandom();
            s = $urandom();
        end
    endtask

    // Drop valid and hold off until every owed sample has been taken.
    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Offer items; valid stays high between back-to-back items.
    task send_items(int count, int restart_pct, int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain();
            while ($urandom_range(99) < sender_idle)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, ($urandom_range(99) < restart_pct)};
            do
                @(posedge clk);
            while (!s_tready);
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] c0, s0, c1, s1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: both tones stand still at full scale.
        send_items(2, 0, -1);
        send_items(1, 100, -1);
        send_items(1, 0, -1);
        drain();

        // Half-rate tones flip sign every sample, A-law.
        set_tones(COEF_NEG_ONE, '0, COEF_NEG_ONE, '0, LAW_A);
        send_items(1, 100, -1);
        send_items(2, 0, -1);
        drain();

        // Quarter-rate tones turning opposite ways, with equal real parts, mu-law.
        set_tones('0, COEF_POS_ONE, '0, COEF_NEG_ONE, LAW_MU);
        send_items(1, 100, -1);
        send_items(3, 0, -1);
        drain();

        // Out-of-range coefficients drive the phasors and sample into saturation.
        set_tones(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, LAW_A);
        send_items(1, 100, -1);
        send_items(3, 0, -1);
        drain();

        // Writes to unimplemented indexes must leave the settings alone.
        cfg_write(REG_SPARE_LO, '1);
        cfg_write(REG_SPARE_HI, 32'h5555_5555);
        cfg_end();
        send_items(2, 0, -1);
        drain();

        // A telephone keypad tone pair in both laws.
        set_tones(to_q30($cos(TWO_PI * 697.0 / SAMPLE_HZ)),
                  to_q30($sin(TWO_PI * 697.0 / SAMPLE_HZ)),
                  to_q30($cos(TWO_PI * 1209.0 / SAMPLE_HZ)),
                  to_q30($sin(TWO_PI * 1209.0 / SAMPLE_HZ)),
                  LAW_MU);
        send_items(1, 100, -1);
        send_items(2, 0, -1);
        drain();
        cfg_write(REG_LAW_SELECT, CFG_DATA_W'(LAW_A));
        cfg_end();
        send_items(2, 0, -1);
        drain();

        // Random settings, cycling through the idling patterns.
        for (int p = 0; p < 16; p++)
        begin
            case (p % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 84; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 84; end
                default: begin sender_idle = 10; recv_stall = 10; end
            endcase
            pick_tone(c0, s0);
            pick_tone(c1, s1);
            set_tones(c0, s0, c1, s1, 1'($urandom_range(1)));
            send_items(102, 5, 51);
            drain();
        end

        repeat (END_WAIT) @(posedge clk);

        $display("Covered %0d samples over %0d coefficient settings, %0d of them restarting.",
                 sb.checked, settings_used, sb.restarts);
        $display("Mu-law %0d, A-law %0d, clipped linear samples %0d, mismatches %0d.",
                 sb.mu_count, sb.a_count, sb.clipped, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
